// File: hdl/dmx_pkg.sv
// Shared types and constants for the DMX512 slot capture block.
package dmx_pkg;

   localparam int MAX_SLOTS       = 512;
   localparam int ADDR_WIDTH      = 10;
   localparam int COUNT_WIDTH     = 8;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 10;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_ADDRESS = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHANNEL_COUNT = 4'd1;

   localparam logic [ADDR_WIDTH-1:0]  START_ADDRESS_RESET = 10'd1;
   localparam logic [COUNT_WIDTH-1:0] CHANNEL_COUNT_RESET = 8'd8;
   localparam logic [ADDR_WIDTH-1:0]  MAX_SLOT_ADDR       = ADDR_WIDTH'(MAX_SLOTS);

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_BREAK  = 4'b0010,
      MODE_START  = 4'b0100,
      MODE_RECORD = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       framing_error;
   } req_type;

   typedef struct packed {
      logic [7:0] slot_index;
      logic [7:0] slot_value;
      logic       frame_done;
   } rsp_type;

   // effective (clamped) configuration handed to the capture logic
   typedef struct packed {
      logic [ADDR_WIDTH-1:0]  start_address;
      logic [COUNT_WIDTH-1:0] channel_count;
   } cfg_type;

endpackage

// File: hdl/dmx_csr.sv
// Configuration registers with clamping of start address and channel count.
module dmx_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dmx_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [dmx_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output dmx_pkg::cfg_type                     cfg
);

   logic [dmx_pkg::ADDR_WIDTH-1:0]  start_address_ff;
   logic [dmx_pkg::COUNT_WIDTH-1:0] channel_count_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_address_ff <= dmx_pkg::START_ADDRESS_RESET;
         channel_count_ff <= dmx_pkg::CHANNEL_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == dmx_pkg::CSR_START_ADDRESS) begin
            start_address_ff <= csr_data;
         end else if (csr_index == dmx_pkg::CSR_CHANNEL_COUNT) begin
            channel_count_ff <= csr_data[dmx_pkg::COUNT_WIDTH-1:0];
         end
      end
   end

   always_comb begin
      priority if (start_address_ff == '0) begin
         cfg.start_address = dmx_pkg::ADDR_WIDTH'(1);
      end else if (start_address_ff > dmx_pkg::MAX_SLOT_ADDR) begin
         cfg.start_address = dmx_pkg::MAX_SLOT_ADDR;
      end else begin
         cfg.start_address = start_address_ff;
      end
      cfg.channel_count = (channel_count_ff == '0) ? dmx_pkg::COUNT_WIDTH'(1)
                                                  : channel_count_ff;
   end

endmodule

// File: hdl/dmx_capture.sv
// Frame state machine, slot countdown and registered result stage.
module dmx_capture (
   input  logic             clock,
   input  logic             reset,
   input  dmx_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  dmx_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dmx_pkg::rsp_type rsp_data
);

   dmx_pkg::mode_type               mode_ff, mode_in;
   logic [dmx_pkg::ADDR_WIDTH-1:0]  countdown_ff, countdown_in;
   logic [dmx_pkg::ADDR_WIDTH-1:0]  countdown_dec;
   logic [7:0]                      write_index_ff, write_index_in;
   logic [8:0]                      write_index_next;
   logic                            rsp_valid_ff, rsp_valid_in;
   dmx_pkg::rsp_type                rsp_ff, rsp_in;
   logic                            accept;
   logic                            hit;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign countdown_dec    = countdown_ff - dmx_pkg::ADDR_WIDTH'(1);
   assign write_index_next = {1'b0, write_index_ff} + 9'd1;

   always_comb begin
      mode_in        = mode_ff;
      countdown_in   = countdown_ff;
      write_index_in = write_index_ff;
      hit            = 1'b0;
      rsp_in.slot_index = write_index_ff;
      rsp_in.slot_value = req_data.rx_byte;
      rsp_in.frame_done = 1'b0;
      if (accept) begin
         if (req_data.framing_error) begin
            countdown_in = cfg.start_address;
            mode_in      = dmx_pkg::MODE_BREAK;
         end else begin
            unique case (mode_ff)
               dmx_pkg::MODE_IDLE: begin
                  mode_in = dmx_pkg::MODE_IDLE;
               end
               dmx_pkg::MODE_BREAK: begin
                  if (req_data.rx_byte == 8'd0) begin
                     mode_in        = dmx_pkg::MODE_START;
                     write_index_in = 8'd1;
                  end else begin
                     mode_in = dmx_pkg::MODE_IDLE;
                  end
               end
               dmx_pkg::MODE_START: begin
                  countdown_in = countdown_dec;
                  if (countdown_dec == '0) begin
                     hit               = 1'b1;
                     rsp_in.slot_index = 8'd0;
                     if (cfg.channel_count <= dmx_pkg::COUNT_WIDTH'(1)) begin
                        mode_in           = dmx_pkg::MODE_IDLE;
                        rsp_in.frame_done = 1'b1;
                     end else begin
                        mode_in        = dmx_pkg::MODE_RECORD;
                        write_index_in = 8'd1;
                     end
                  end
               end
               dmx_pkg::MODE_RECORD: begin
                  hit            = 1'b1;
                  write_index_in = write_index_next[7:0];
                  if (write_index_next >= {1'b0, cfg.channel_count}) begin
                     mode_in           = dmx_pkg::MODE_IDLE;
                     rsp_in.frame_done = 1'b1;
                  end
               end
               default: begin
                  mode_in = dmx_pkg::MODE_IDLE;
               end
            endcase
         end
      end
      rsp_valid_in = hit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= dmx_pkg::MODE_IDLE;
         countdown_ff   <= '0;
         write_index_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         countdown_ff   <= countdown_in;
         write_index_ff <= write_index_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: hdl/dmx512_slot_capture.sv
// DMX512 slot capture top level: configuration registers and capture stage.
// A captured slot is registered and appears on rsp in the cycle after its request is taken.
// Throughput: one request per cycle; requests stall only while a result waits.
// Bytes that capture no slot (idle, break, start code, countdown) give no result.
// Reset (synchronous, active high): idle mode, countdown and index cleared,
// start_address = 1, channel_count = 8, result stage empty.
module dmx512_slot_capture (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  dmx_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output dmx_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dmx_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [dmx_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   dmx_pkg::cfg_type cfg;

   dmx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dmx_capture u_capture (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hdl/dmx_checker.sv
// Port-level checker for the DMX512 slot capture block, bound to the top level.
module dmx_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input dmx_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input dmx_pkg::rsp_type rsp_data
);

   // a waiting result holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // a break request never produces a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.framing_error |=> !rsp_valid)
      else $error("result after break request");

   // requests stall only behind a waiting result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with no result waiting");

   // window index stays within 0..254
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.slot_index != 8'd255)
      else $error("slot index out of range");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind dmx512_slot_capture dmx_checker u_dmx_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
